/* rtl/lcp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types, command codes and character helpers for the line command
// parser.
// ----------------------------------------------------------------------------
package lcp_pkg;

  // Command kinds reported per line
  localparam logic [2:0] KIND_INVALID = 3'd0;
  localparam logic [2:0] KIND_START   = 3'd1;
  localparam logic [2:0] KIND_STOP    = 3'd2;
  localparam logic [2:0] KIND_STATUS  = 3'd3;
  localparam logic [2:0] KIND_HELP    = 3'd4;
  localparam logic [2:0] KIND_RED     = 3'd5;
  localparam logic [2:0] KIND_GREEN   = 3'd6;
  localparam logic [2:0] KIND_YELLOW  = 3'd7;

  // Duration prefixes
  localparam logic [1:0] PREFIX_NONE = 2'd0;
  localparam logic [1:0] PREFIX_R    = 2'd1;
  localparam logic [1:0] PREFIX_G    = 2'd2;
  localparam logic [1:0] PREFIX_Y    = 2'd3;

  // Characters
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W    = 1;
  localparam logic [0:0]  REG_MIN_DUR  = 1'b0;
  localparam logic [0:0]  REG_MAX_DUR  = 1'b1;

  localparam int unsigned CFG_W = 16;
  localparam int unsigned DUR_W = 16;

  // One decoded line
  typedef struct packed {
    logic [2:0]       kind;
    logic [DUR_W-1:0] duration;
  } lcp_result_t;

  // Space, tab, CR, LF, FF, VT
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a) ||
           (c == 8'h0c) || (c == 8'h0b);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ? (c - CASE_GAP) : c;
  endfunction

  // Keyword lengths: START, STOP, STATUS, HELP
  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] len;
    case (k)
      2'd0:    len = 3'd5;
      2'd1:    len = 3'd4;
      2'd2:    len = 3'd6;
      default: len = 3'd4;
    endcase
    return len;
  endfunction

  // Keyword character at a position; zero past the end
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [47:0] text;
    logic [7:0]  ch;
    case (k)
      2'd0:    text = {8'h00, "START"};
      2'd1:    text = {16'h0000, "STOP"};
      2'd2:    text = "STATUS";
      default: text = {16'h0000, "HELP"};
    endcase
    // text holds the first character in its top used byte
    case (pos)
      3'd0:    ch = (k == 2'd2) ? text[47:40] : (k == 2'd0) ? text[39:32] : text[31:24];
      3'd1:    ch = (k == 2'd2) ? text[39:32] : (k == 2'd0) ? text[31:24] : text[23:16];
      3'd2:    ch = (k == 2'd2) ? text[31:24] : (k == 2'd0) ? text[23:16] : text[15:8];
      3'd3:    ch = (k == 2'd2) ? text[23:16] : (k == 2'd0) ? text[15:8]  : text[7:0];
      3'd4:    ch = (k == 2'd2) ? text[15:8]  : (k == 2'd0) ? text[7:0]   : 8'h00;
      3'd5:    ch = (k == 2'd2) ? text[7:0]   : 8'h00;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

/* rtl/lcp_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcp_scan
// Per-line scanner state: whitespace phases, keyword match, prefix and
// decimal accumulator. Gives the decoded result of the line seen so far.
// ----------------------------------------------------------------------------
module lcp_scan #(
  parameter int unsigned DURATION_BITS = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      char_take_i,   // character transaction
  input  wire                      line_take_i,   // end-of-line transaction
  input  wire  [7:0]               char_code_i,
  input  wire  [lcp_pkg::CFG_W-1:0] min_dur_i,
  input  wire  [lcp_pkg::CFG_W-1:0] max_dur_i,
  output lcp_pkg::lcp_result_t     result_o
);
  import lcp_pkg::*;

  // compare width covers both the accumulator and the register values
  localparam int unsigned BASE_W = (DURATION_BITS > CFG_W) ? DURATION_BITS : CFG_W;
  localparam int unsigned MW = BASE_W + 4;
  localparam logic [MW-1:0] CAP = {{(MW-DURATION_BITS){1'b0}}, {DURATION_BITS{1'b1}}};

  // Scan phases
  localparam logic [1:0] PH_LEAD   = 2'd0;
  localparam logic [1:0] PH_TOKEN  = 2'd1;
  localparam logic [1:0] PH_TRAIL  = 2'd2;
  localparam logic [1:0] PH_BROKEN = 2'd3;

  logic [1:0]               phase_q, phase_d;
  logic [2:0]               pos_q, pos_d;
  logic [3:0]               alive_q, alive_d;
  logic [1:0]               prefix_q, prefix_d;
  logic [DURATION_BITS-1:0] accum_q, accum_d;
  logic                     fault_q, fault_d;
  logic                     digit_q, digit_d;

  logic [7:0]    up;
  logic [MW-1:0] max_ext;
  logic [MW-1:0] eff_max;
  logic [MW-1:0] acc_ext;
  logic [MW-1:0] next_val;
  logic          is_digit;

  assign up       = to_upper(char_code_i);
  assign max_ext  = MW'(max_dur_i);
  assign eff_max  = (max_ext < CAP) ? max_ext : CAP;
  assign acc_ext  = MW'(accum_q);
  // value * 10 + digit; the accumulator never exceeds eff_max, so no overflow
  assign next_val = {acc_ext[MW-4:0], 3'b000} + {acc_ext[MW-2:0], 1'b0} +
                    MW'(char_code_i[3:0]);
  assign is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);

  // Next state for one character
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    alive_d  = alive_q;
    prefix_d = prefix_q;
    accum_d  = accum_q;
    fault_d  = fault_q;
    digit_d  = digit_q;
    if (is_blank(char_code_i)) begin
      if (phase_q == PH_TOKEN) begin
        phase_d = PH_TRAIL;
      end
    end else if ((phase_q == PH_TRAIL) || (phase_q == PH_BROKEN)) begin
      phase_d = PH_BROKEN;
    end else begin
      phase_d = PH_TOKEN;
      for (int k = 0; k < 4; k++) begin
        if ((pos_q >= kw_len(2'(k))) || (up != kw_char(2'(k), pos_q))) begin
          alive_d[k] = 1'b0;
        end
      end
      if (pos_q == 3'd0) begin
        if (up == CH_R) begin
          prefix_d = PREFIX_R;
        end else if (up == CH_G) begin
          prefix_d = PREFIX_G;
        end else if (up == CH_Y) begin
          prefix_d = PREFIX_Y;
        end else begin
          prefix_d = PREFIX_NONE;
        end
      end else if (!fault_q) begin
        if (!is_digit) begin
          fault_d = 1'b1;
        end else begin
          digit_d = 1'b1;
          // 10*v + digit > max covers the pre-multiply overflow test as well
          if (next_val > eff_max) begin
            fault_d = 1'b1;
          end else begin
            accum_d = next_val[DURATION_BITS-1:0];
          end
        end
      end
      if (pos_q != 3'd7) begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  // State registers; each line end returns to the reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEAD;
      pos_q    <= 3'd0;
      alive_q  <= 4'hf;
      prefix_q <= PREFIX_NONE;
      accum_q  <= '0;
      fault_q  <= 1'b0;
      digit_q  <= 1'b0;
    end else if (line_take_i) begin
      phase_q  <= PH_LEAD;
      pos_q    <= 3'd0;
      alive_q  <= 4'hf;
      prefix_q <= PREFIX_NONE;
      accum_q  <= '0;
      fault_q  <= 1'b0;
      digit_q  <= 1'b0;
    end else if (char_take_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      alive_q  <= alive_d;
      prefix_q <= prefix_d;
      accum_q  <= accum_d;
      fault_q  <= fault_d;
      digit_q  <= digit_d;
    end
  end

  // Decode of the line held in the state
  always_comb begin
    result_o.kind     = KIND_INVALID;
    result_o.duration = '0;
    if ((phase_q == PH_TOKEN) || (phase_q == PH_TRAIL)) begin
      // descending so the first keyword in the list wins
      for (int k = 3; k >= 0; k--) begin
        if (alive_q[k] && (pos_q == kw_len(2'(k)))) begin
          result_o.kind = 3'(k + 1);
        end
      end
      if ((result_o.kind == KIND_INVALID) && (prefix_q != PREFIX_NONE) && digit_q &&
          !fault_q && (acc_ext >= MW'(min_dur_i))) begin
        result_o.kind     = KIND_HELP + {1'b0, prefix_q};
        result_o.duration = DUR_W'(accum_q);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/line_command_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// line_command_parser
// Decodes a text line, one character per transaction, into one command per
// line end.
// ----------------------------------------------------------------------------
//  channel  | direction | transfers
//  s_axis   | in        | tdata: char_code, tlast: line_end
//  m_axis   | out       | tdata: command_kind, duration (one per line end)
//  cfg      | in        | index 0 min_duration, index 1 max_duration
//
// One input transaction per cycle while s_axis_tready is high; each line end's
// command is registered into the result register, or into the skid entry if that is full.
// A two-entry output register (result plus skid) lets input continue while
// a result waits; input stalls only when both entries are full.
// Reset clears the scanner and loads min_duration 1, max_duration 999.
// ----------------------------------------------------------------------------
module line_command_parser #(
  parameter int unsigned DURATION_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // character stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire         s_axis_tlast,   // line_end
  // command stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] command_kind, [18:3] duration, rest 0
  // register writes
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [lcp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [lcp_pkg::CFG_W-1:0]     cfg_data_i
);
  import lcp_pkg::*;

  logic [CFG_W-1:0] min_dur_q;
  logic [CFG_W-1:0] max_dur_q;
  logic             in_take;
  logic             char_take;
  logic             line_take;
  logic             pop;
  lcp_result_t      line_result;
  lcp_result_t      out_q;
  lcp_result_t      skid_q;
  logic             out_valid_q;
  logic             skid_valid_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dur_q <= CFG_W'(1);
      max_dur_q <= CFG_W'(999);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MIN_DUR: min_dur_q <= cfg_data_i;
        REG_MAX_DUR: max_dur_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Input handshake
  assign s_axis_tready = !skid_valid_q;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign char_take     = in_take && !s_axis_tlast;
  assign line_take     = in_take && s_axis_tlast;

  lcp_scan #(
    .DURATION_BITS(DURATION_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_take_i (char_take),
    .line_take_i (line_take),
    .char_code_i (s_axis_tdata),
    .min_dur_i   (min_dur_q),
    .max_dur_i   (max_dur_q),
    .result_o    (line_result)
  );

  // Output register with skid entry
  assign pop = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (line_take && (!out_valid_q || pop)) begin
        out_valid_q <= 1'b1;
      end else if (line_take) begin
        skid_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_take && (!out_valid_q || pop)) begin
      out_q <= line_result;
    end else if (line_take) begin
      skid_q <= line_result;
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_q.duration, out_q.kind};

  // Checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds data while output entry is empty");

  a_line_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_take |=> m_axis_tvalid)
    else $error("line end did not produce a result");

  a_char_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_take && !out_valid_q) |=> !m_axis_tvalid)
    else $error("character produced a result");

  a_dur_only_for_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:0] != KIND_RED) && (m_axis_tdata[2:0] != KIND_GREEN)
     && (m_axis_tdata[2:0] != KIND_YELLOW)) |-> (m_axis_tdata[18:3] == '0))
    else $error("nonzero duration on a command without one");

endmodule
`default_nettype wire

/* tb/line_command_parser_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// line_command_parser_test
// Self-checking bench for the line command parser. Text lines go in one
// character per transaction, each closed by a line-end transaction; a local
// decoder tracks the scanner state and queues the command each line should
// give. Directed lines cover keywords, durations, malformed lines and register
// extremes, then random lines run under several register settings with the
// sender and receiver stalling in turn.
// ----------------------------------------------------------------------------
module line_command_parser_test;
  import lcp_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned END_WAIT      = 5000;
  localparam int unsigned BATCH_ITEMS   = 195;

  typedef enum logic [1:0] {SCAN_LEAD, SCAN_TOKEN, SCAN_TRAIL, SCAN_BROKEN} scan_state_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;   // [7:0] char_code
  logic                 s_axis_tlast  = 1'b0; // line_end
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;         // [2:0] command_kind, [18:3] duration
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  line_command_parser DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Keyword table, in priority order
  string      kw_words [4] = '{"START", "STOP", "STATUS", "HELP"};
  logic [2:0] kw_kinds [4] = '{KIND_START, KIND_STOP, KIND_STATUS, KIND_HELP};
  logic [7:0] blank_codes [6] = '{8'h20, 8'h09, 8'h0d, 8'h0a, 8'h0c, 8'h0b};

  // Decoder copy of registers and scanner state
  logic [15:0] cfg_min;
  logic [15:0] cfg_max;
  scan_state_e scan_state;
  logic [2:0]  tok_count;
  logic [3:0]  words_alive;
  logic [1:0]  prefix_sel;
  logic [15:0] value_acc;
  logic        value_bad;
  logic        value_digit;

  lcp_result_t pending_cmds [$];
  logic [7:0]  line_buf [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned lines_sent    = 0;
  int unsigned cmds_checked  = 0;
  int unsigned settings_used = 0;
  int unsigned kind_hits [8] = '{default: 0};
  lcp_result_t cmd_want;
  lcp_result_t cmd_got;

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit of %0d reached, still waiting", $time, CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic blank_char(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0d, 8'h0a, 8'h0c, 8'h0b};
  endfunction

  function automatic void clear_scanner();
    scan_state  = SCAN_LEAD;
    tok_count   = '0;
    words_alive = 4'hf;
    prefix_sel  = PREFIX_NONE;
    value_acc   = '0;
    value_bad   = 1'b0;
    value_digit = 1'b0;
  endfunction

  // Advance the decoder by one accepted transaction; a line end queues a command
  function automatic void decode_item(input logic [7:0] ch, input logic eol);
    logic [7:0]  up;
    int unsigned v;
    string       w;
    lcp_result_t cmd;
    if (eol) begin
      cmd.kind     = KIND_INVALID;
      cmd.duration = '0;
      if (scan_state == SCAN_TOKEN || scan_state == SCAN_TRAIL) begin
        for (int k = 0; k < 4; k++) begin
          if (cmd.kind == KIND_INVALID && words_alive[k] && tok_count == kw_words[k].len())
            cmd.kind = kw_kinds[k];
        end
        if (cmd.kind == KIND_INVALID && prefix_sel != PREFIX_NONE && value_digit &&
            !value_bad && value_acc >= cfg_min) begin
          case (prefix_sel)
            PREFIX_R: cmd.kind = KIND_RED;
            PREFIX_G: cmd.kind = KIND_GREEN;
            default:  cmd.kind = KIND_YELLOW;
          endcase
          cmd.duration = value_acc;
        end
      end
      pending_cmds.push_back(cmd);
      clear_scanner();
      return;
    end
    // blanks only move the phase
    if (blank_char(ch)) begin
      if (scan_state == SCAN_TOKEN) scan_state = SCAN_TRAIL;
      return;
    end
    if (scan_state == SCAN_TRAIL || scan_state == SCAN_BROKEN) begin
      scan_state = SCAN_BROKEN;
      return;
    end
    scan_state = SCAN_TOKEN;
    up = (ch >= CH_LOW_A && ch <= CH_LOW_Z) ? ch - 8'h20 : ch;
    for (int k = 0; k < 4; k++) begin
      w = kw_words[k];
      if (tok_count >= w.len() || up != w[tok_count]) words_alive[k] = 1'b0;
    end
    // first character picks the prefix, the rest feed the number
    if (tok_count == 0) begin
      case (up)
        CH_R:    prefix_sel = PREFIX_R;
        CH_G:    prefix_sel = PREFIX_G;
        CH_Y:    prefix_sel = PREFIX_Y;
        default: prefix_sel = PREFIX_NONE;
      endcase
    end else if (!value_bad) begin
      if (ch < CH_ZERO || ch > CH_NINE) begin
        value_bad = 1'b1;
      end else begin
        v = value_acc;
        if (v > cfg_max / 10) begin
          value_bad = 1'b1;
        end else begin
          v = v * 10 + (ch - CH_ZERO);
          if (v > cfg_max) value_bad = 1'b1;
          else value_acc = v[15:0];
        end
        value_digit = 1'b1;
      end
    end
    if (tok_count < 3'd7) tok_count = tok_count + 1'b1;
  endfunction

  // Command checker and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      cmd_got.kind     = m_axis_tdata[2:0];
      cmd_got.duration = m_axis_tdata[18:3];
      kind_hits[cmd_got.kind] = kind_hits[cmd_got.kind] + 1;
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected command, kind %0d duration %0d", $time,
                 cmd_got.kind, cmd_got.duration);
        error_count = error_count + 1;
      end else begin
        cmd_want = pending_cmds.pop_front();
        cmds_checked = cmds_checked + 1;
        if (cmd_got.kind != cmd_want.kind) begin
          $display("%0t: command_kind mismatch: expected %0d, actual %0d", $time,
                   cmd_want.kind, cmd_got.kind);
          error_count = error_count + 1;
        end
        if (cmd_got.duration != cmd_want.duration) begin
          $display("%0t: duration mismatch: expected %0d, actual %0d", $time,
                   cmd_want.duration, cmd_got.duration);
          error_count = error_count + 1;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One character or line-end transaction, with random sender gaps before it
  task automatic send_item(input logic [7:0] ch, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= eol;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_item(ch, eol);
    items_sent = items_sent + 1;
  endtask

  // Send line_buf then a line end carrying a random (ignored) character
  task automatic send_buffered_line();
    foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
    lines_sent = lines_sent + 1;
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_buffered_line();
  endtask

  // Hold the sender until every queued command has come back
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_MIN_DUR) cfg_min = val;
    else cfg_max = val;
  endtask

  task automatic apply_setting(input logic [15:0] lo, input logic [15:0] hi);
    write_reg(REG_MIN_DUR, lo);
    write_reg(REG_MAX_DUR, hi);
    settings_used = settings_used + 1;
  endtask

  // Build one random line: mostly keywords and durations, some broken or noise
  task automatic make_random_line();
    logic [7:0]  tok [$];
    string       text;
    int unsigned shape;
    int unsigned v;
    int unsigned lo;
    line_buf.delete();
    shape = $urandom_range(99);
    if (shape < 45) begin
      text = kw_words[$urandom_range(3)];
      for (int i = 0; i < text.len(); i++)
        tok.push_back($urandom_range(1) ? text[i] + 8'h20 : text[i]);
      case ($urandom_range(14))
        0: tok.pop_back();
        1: tok.push_back(8'(8'h41 + $urandom_range(25)));
        2: tok[$urandom_range(tok.size() - 1)] = 8'($urandom_range(255));
        default: ;
      endcase
    end else if (shape < 88) begin
      text = "RGYrgy";
      tok.push_back(text[$urandom_range(5)]);
      if ($urandom_range(11) != 0) begin
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 2)) tok.push_back(CH_ZERO);
        lo = (cfg_min <= cfg_max) ? cfg_min : cfg_max;
        case ($urandom_range(7))
          0: v = cfg_min;
          1: v = cfg_max;
          2: v = cfg_max + 1;
          3: v = (cfg_min > 0) ? cfg_min - 1 : 0;
          4: v = $urandom_range(99999);
          default: v = $urandom_range(cfg_max, lo);
        endcase
        text = $sformatf("%0d", v);
        for (int i = 0; i < text.len(); i++) tok.push_back(text[i]);
        if ($urandom_range(9) == 0)
          tok[$urandom_range(tok.size() - 1, 1)] = 8'($urandom_range(255));
      end
    end else begin
      repeat ($urandom_range(6)) tok.push_back(8'($urandom_range(255)));
    end
    // blank inside the token
    if (shape < 88 && tok.size() > 1 && $urandom_range(9) == 0)
      tok.insert($urandom_range(tok.size() - 1, 1), blank_codes[$urandom_range(5)]);
    if ($urandom_range(2) == 0)
      repeat ($urandom_range(1, 2)) line_buf.push_back(blank_codes[$urandom_range(5)]);
    foreach (tok[i]) line_buf.push_back(tok[i]);
    if ($urandom_range(2) == 0)
      repeat ($urandom_range(1, 2)) line_buf.push_back(blank_codes[$urandom_range(5)]);
  endtask

  // ---- Tests ----

  task automatic test_keywords();
    send_text("START");
    send_text(" stop\011");
    send_text("StAtUs");
    send_text("hElP\015");
  endtask

  task automatic test_durations();
    send_text("R1");
    send_text("g999");
    send_text("Y1000");
    send_text("y0");
    send_text("G");
  endtask

  task automatic test_malformed_lines();
    send_text("");
    send_text("\014 \012");
    send_text("HE LP");
    send_text("R12x");
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b1);
    lines_sent = lines_sent + 1;
  endtask

  task automatic test_register_limits();
    apply_setting(16'd0, 16'hffff);
    send_text("R65535");
    send_text("G0");
    send_text("Y65536");
    apply_setting(16'hffff, 16'hffff);
    send_text("r65535");
    send_text("g65534");
    apply_setting(16'd7, 16'd3);
    send_text("y5");
  endtask

  task automatic test_random_lines();
    int unsigned batch_start;
    int unsigned lo;
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 16; recv_idle_pct = 82; end
        1: begin send_idle_pct = 82; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int b = 0; b < 3; b++) begin
        case (p * 3 + b)
          0: apply_setting(16'd1, 16'd999);
          1: apply_setting(16'd0, 16'hffff);
          2: apply_setting(16'hffff, 16'hffff);
          3: apply_setting(16'd0, 16'd0);
          4: apply_setting(16'd500, 16'd100);
          5: begin
            lo = $urandom_range(2000);
            apply_setting(16'(lo), 16'(lo + $urandom_range(3000)));
          end
          6: apply_setting(16'd10, 16'd99);
          7: begin
            lo = $urandom_range(65535);
            apply_setting(16'(lo), 16'($urandom_range(65535, lo)));
          end
          default: apply_setting(16'd1, 16'd999);
        endcase
        batch_start = items_sent;
        while (items_sent - batch_start < BATCH_ITEMS) begin
          make_random_line();
          send_buffered_line();
          if ($urandom_range(49) == 0) wait_for_results();
        end
      end
    end
  endtask

  // Main sequence
  initial begin
    cfg_min = 16'd1;
    cfg_max = 16'd999;
    clear_scanner();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 16;
    recv_idle_pct = 82;
    test_keywords();
    test_durations();
    test_malformed_lines();
    test_register_limits();
    test_random_lines();

    // drain, then let the pipeline settle
    s_axis_tvalid <= 1'b0;
    for (int n = 0; n < END_WAIT && pending_cmds.size() != 0; n++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_cmds.size() != 0) begin
      $display("%0t: %0d commands never came out", $time, pending_cmds.size());
      error_count = error_count + 1;
    end

    $display("Sent %0d lines in %0d transactions under %0d register settings; %0d commands checked.",
             lines_sent, items_sent, settings_used, cmds_checked);
    $display("Kinds seen invalid/start/stop/status/help/red/green/yellow: %0d %0d %0d %0d %0d %0d %0d %0d",
             kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3],
             kind_hits[4], kind_hits[5], kind_hits[6], kind_hits[7]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
rtl/lcp_pkg.sv
rtl/lcp_scan.sv
rtl/line_command_parser.sv
tb/line_command_parser_test.sv
